### hw/rtl/sre_pkg.sv
// Shared types and constants for the sonar range extractor.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package sre_pkg;

  // Register and field widths
  localparam int BC_W   = 11;
  localparam int RS_W   = 8;
  localparam int MR_W   = 8;
  localparam int WL_W   = 7;
  localparam int TH_W   = 8;
  localparam int SMP_W  = 8;
  localparam int RNG_W  = 16;
  localparam int PEAK_W = 10;
  localparam int LVL_W  = 8;
  localparam int CFG_W  = 11;
  localparam int IDX_W  = 3;

  // min_range * bin_count / range_span keeps full precision
  localparam int SKIP_W = MR_W + BC_W;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_BIN_COUNT     = 3'd0;
  localparam logic [IDX_W-1:0] REG_RANGE_SPAN    = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_RANGE     = 3'd2;
  localparam logic [IDX_W-1:0] REG_WINDOW_LENGTH = 3'd3;
  localparam logic [IDX_W-1:0] REG_THRESHOLD     = 3'd4;

  // Register reset values
  localparam logic [BC_W-1:0] BIN_COUNT_RST     = 11'd600;
  localparam logic [RS_W-1:0] RANGE_SPAN_RST    = 8'd70;
  localparam logic [MR_W-1:0] MIN_RANGE_RST     = 8'd10;
  localparam logic [WL_W-1:0] WINDOW_LENGTH_RST = 7'd20;
  localparam logic [TH_W-1:0] THRESHOLD_RST     = 8'd0;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_SKIP,
    ST_RANGE_START,
    ST_RANGE,
    ST_COUNT
  } state_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/sre_cell.sv
// One cell of the history chain: holds a word and takes its neighbour's on shift.
// Depends on sre_pkg for the cell control struct.
`default_nettype none

module sre_cell #(
  parameter int DATA_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  sre_pkg::cell_ctrl_t ctrl,
  input  logic [DATA_W-1:0]   d_in,
  output logic [DATA_W-1:0]   q
);
  import sre_pkg::*;

  // clear wins over shift: the last bin of a scan wipes the chain instead of shifting in
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (ctrl.clear) begin
      q <= '0;
    end else if (ctrl.shift) begin
      q <= d_in;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sre_div.sv
// Restoring divider, one quotient bit per cycle, shared by the skip and range terms.
// Depends on sre_pkg.
`default_nettype none

module sre_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);
  import sre_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    diff  = trial - {1'b0, den};
    ge    = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], ge};
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

### hw/rtl/sonar_range_extractor.sv
// Top level of the sonar range extractor: config registers, sequencer, cell chains.
// Depends on sre_pkg, sre_cell and sre_div.
//
//   channel   signals                               request
//   config    cfg_we, cfg_index, cfg_data           one register write per cycle
//   sample    sample_valid/ready, sample_value      one intensity bin
//   result    result_valid/ready, range_q8_8,       one peak per scan
//             peak_bin, peak_level
//
// Bins stream in while sample_ready is high. The first bin of a scan is followed by a stall
// while the shared divider works out the skipped bins; after the last bin the divider
// computes the range and sample_ready stays low until it is done and any earlier result is
// taken (the divider is NUM_W wide: the larger of clog2(BIN_MAX) + 16 and SKIP_W, 26 at the
// defaults). A window_length write makes the history recount before the next bin. Reset is
// synchronous; a result held by result_ready low stalls only the end of the following scan.
`default_nettype none

module sonar_range_extractor #(
  parameter int BIN_MAX    = 1024,
  parameter int WINDOW_MAX = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [sre_pkg::IDX_W-1:0]   cfg_index,
  input  logic [sre_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  logic [sre_pkg::SMP_W-1:0]   sample_value,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [sre_pkg::RNG_W-1:0]   range_q8_8,
  output logic [sre_pkg::PEAK_W-1:0]  peak_bin,
  output logic [sre_pkg::LVL_W-1:0]   peak_level
);
  import sre_pkg::*;

  localparam int POS_W       = $clog2(BIN_MAX);
  localparam int DELAY_DEPTH = WINDOW_MAX - WINDOW_MAX / 2;
  localparam int WC_W        = $clog2(WINDOW_MAX + 1);
  localparam int WI_W        = $clog2(WINDOW_MAX);
  localparam int DI_W        = $clog2(DELAY_DEPTH);
  localparam int CMP_W       = ((POS_W > SKIP_W) ? POS_W : SKIP_W) + 1;
  localparam int RNUM_W      = POS_W + RS_W + 8;
  localparam int NUM_W       = (RNUM_W > SKIP_W) ? RNUM_W : SKIP_W;

  // Configuration registers
  logic [BC_W-1:0] bin_count;
  logic [RS_W-1:0] range_span;
  logic [MR_W-1:0] min_range;
  logic [WL_W-1:0] window_length;
  logic [TH_W-1:0] threshold;

  // Scan state
  state_t            state;
  state_t            state_next;
  logic [POS_W-1:0]  pos;
  logic [WC_W-1:0]   viw;
  logic [LVL_W-1:0]  best_level;
  logic [POS_W-1:0]  best_bin;
  logic [SKIP_W-1:0] skip;
  logic              recount_pend;
  logic [WI_W-1:0]   cnt_idx;
  logic [POS_W-1:0]  res_bin;
  logic [LVL_W-1:0]  res_level;

  // Effective settings
  logic [BC_W-1:0]  bc;
  logic [RS_W-1:0]  rs;
  logic [WC_W-1:0]  wc;
  logic [WC_W-1:0]  half;
  logic [WC_W-1:0]  dly;

  // Chains
  cell_ctrl_t       cell_ctrl;
  logic [WINDOW_MAX-1:0] vh_q;
  logic [WINDOW_MAX-1:0] vh_d;
  logic [SMP_W-1:0] sd_q [DELAY_DEPTH];
  logic [SMP_W-1:0] sd_d [DELAY_DEPTH];

  // Step datapath
  logic              accept;
  logic              vnew;
  logic [WI_W-1:0]   rd_idx;
  logic              dropped;
  logic [WC_W-1:0]   viw_next;
  logic [SMP_W-1:0]  level_src;
  logic [LVL_W-1:0]  level;
  logic [CMP_W-1:0]  p1;
  logic [CMP_W-1:0]  start_x;
  logic [CMP_W-1:0]  bin_x;
  logic              judged;
  logic              upd;
  logic              last;
  logic [LVL_W-1:0]  best_level_next;
  logic [POS_W-1:0]  best_bin_next;

  // Divider
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [BC_W-1:0]   div_den;
  logic              div_busy;
  logic [NUM_W-1:0]  div_quo;
  logic [RNUM_W-1:0] range_num;
  logic [SKIP_W-1:0] skip_num;

  always_comb begin
    if (bin_count == '0) begin
      bc = BC_W'(1);
    end else if (32'(bin_count) > BIN_MAX) begin
      bc = BC_W'(BIN_MAX);
    end else begin
      bc = bin_count;
    end
    rs = (range_span == '0) ? RS_W'(1) : range_span;
    if (32'(window_length) < 2) begin
      wc = WC_W'(2);
    end else if (32'(window_length) > WINDOW_MAX) begin
      wc = WC_W'(WINDOW_MAX);
    end else begin
      wc = WC_W'(window_length);
    end
    half = wc >> 1;
    dly  = wc - WC_W'(1) - half;
  end

  // History chains
  assign vnew = (sample_value > threshold);
  assign vh_d = {vh_q[WINDOW_MAX-2:0], vnew};

  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_valid
    sre_cell #(.DATA_W(1)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (cell_ctrl),
      .d_in (vh_d[k]),
      .q    (vh_q[k])
    );
  end

  for (genvar k = 0; k < DELAY_DEPTH; k++) begin : g_sample
    if (k == 0) begin : g_head
      assign sd_d[k] = sample_value;
    end else begin : g_body
      assign sd_d[k] = sd_q[k-1];
    end
    sre_cell #(.DATA_W(SMP_W)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (cell_ctrl),
      .d_in (sd_d[k]),
      .q    (sd_q[k])
    );
  end

  // Judge the bin half a window back
  always_comb begin
    accept   = sample_valid && sample_ready;
    rd_idx   = (state == ST_COUNT) ? cnt_idx : WI_W'(wc - WC_W'(1));
    dropped  = vh_q[rd_idx];
    viw_next = viw + WC_W'(vnew) - WC_W'(dropped);

    level_src = (dly == '0) ? sample_value : sd_q[DI_W'(dly - WC_W'(1))];
    level     = (viw_next > half) ? level_src : '0;

    p1      = CMP_W'(pos) + CMP_W'(1);
    start_x = p1 - CMP_W'(wc);
    bin_x   = start_x + CMP_W'(half);
    judged  = (p1 >= CMP_W'(wc)) && (start_x >= CMP_W'(skip))
              && ((bin_x + CMP_W'(half)) < CMP_W'(bc));
    upd     = judged && (level >= best_level);
    last    = (p1 >= CMP_W'(bc));

    best_level_next = upd ? level : best_level;
    best_bin_next   = upd ? POS_W'(bin_x) : best_bin;
  end

  // Divider operands
  always_comb begin
    range_num = (RNUM_W'(res_bin) * RNUM_W'(rs)) << 8;
    skip_num  = SKIP_W'(min_range) * SKIP_W'(bc);
    div_start = (accept && (pos == '0) && !last) || (state == ST_RANGE_START);
    if (state == ST_RANGE_START) begin
      div_num = NUM_W'(range_num);
      div_den = bc;
    end else begin
      div_num = NUM_W'(skip_num);
      div_den = BC_W'(rs);
    end
  end

  sre_div #(.NUM_W(NUM_W), .DEN_W(BC_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (recount_pend) begin
          state_next = ST_COUNT;
        end else if (accept && last) begin
          state_next = ST_RANGE_START;
        end else if (accept && (pos == '0)) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (!div_busy) begin
          state_next = ST_RUN;
        end
      end
      ST_RANGE_START: begin
        state_next = ST_RANGE;
      end
      ST_RANGE: begin
        if (!div_busy && (!result_valid || result_ready)) begin
          state_next = ST_RUN;
        end
      end
      ST_COUNT: begin
        if (cnt_idx >= WI_W'(wc - WC_W'(1))) begin
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    sample_ready    = (state == ST_RUN) && !recount_pend;
    cell_ctrl.shift = accept;
    cell_ctrl.clear = accept && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_RUN;
      bin_count     <= BIN_COUNT_RST;
      range_span    <= RANGE_SPAN_RST;
      min_range     <= MIN_RANGE_RST;
      window_length <= WINDOW_LENGTH_RST;
      threshold     <= THRESHOLD_RST;
      pos           <= '0;
      viw           <= '0;
      best_level    <= '0;
      best_bin      <= '0;
      skip          <= '0;
      recount_pend  <= 1'b0;
      cnt_idx       <= '0;
      result_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_BIN_COUNT:     bin_count     <= cfg_data[BC_W-1:0];
          REG_RANGE_SPAN:    range_span    <= cfg_data[RS_W-1:0];
          REG_MIN_RANGE:     min_range     <= cfg_data[MR_W-1:0];
          REG_WINDOW_LENGTH: window_length <= cfg_data[WL_W-1:0];
          REG_THRESHOLD:     threshold     <= cfg_data[TH_W-1:0];
          default: ;
        endcase
      end

      // a new window length invalidates the running count
      if (cfg_we && (cfg_index == REG_WINDOW_LENGTH)) begin
        recount_pend <= 1'b1;
      end else if ((state == ST_RUN) && (state_next == ST_COUNT)) begin
        recount_pend <= 1'b0;
      end

      if (accept) begin
        if (last) begin
          pos        <= '0;
          viw        <= '0;
          best_level <= '0;
          best_bin   <= '0;
          skip       <= '0;
        end else begin
          pos        <= pos + POS_W'(1);
          viw        <= viw_next;
          best_level <= best_level_next;
          best_bin   <= best_bin_next;
        end
      end else if ((state == ST_RUN) && (state_next == ST_COUNT)) begin
        viw     <= '0;
        cnt_idx <= '0;
      end else if (state == ST_COUNT) begin
        viw     <= viw + WC_W'(dropped);
        cnt_idx <= cnt_idx + WI_W'(1);
      end else if ((state == ST_SKIP) && !div_busy) begin
        skip <= div_quo[SKIP_W-1:0];
      end

      if ((state == ST_RANGE) && (state_next == ST_RUN)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Hold the peak of the finished scan and the result payload
  always_ff @(posedge clk) begin
    if (accept && last) begin
      res_bin   <= best_bin_next;
      res_level <= best_level_next;
    end
    if ((state == ST_RANGE) && (state_next == ST_RUN)) begin
      range_q8_8 <= div_quo[RNG_W-1:0];
      peak_bin   <= PEAK_W'(res_bin);
      peak_level <= res_level;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sre_chk.sv
// Port-level checks for the sonar range extractor, bound to the top level.
// Depends on sre_pkg and sonar_range_extractor.
`default_nettype none

module sre_chk (
  input wire                        clk,
  input wire                        rst,
  input wire                        cfg_we,
  input wire [sre_pkg::IDX_W-1:0]   cfg_index,
  input wire                        sample_valid,
  input wire                        sample_ready,
  input wire                        result_valid,
  input wire                        result_ready,
  input wire [sre_pkg::RNG_W-1:0]   range_q8_8,
  input wire [sre_pkg::PEAK_W-1:0]  peak_bin,
  input wire [sre_pkg::LVL_W-1:0]   peak_level
);
  import sre_pkg::*;

  // a stalled result holds its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(range_q8_8) && $stable(peak_bin) && $stable(peak_level))
    else $error("result payload changed while stalled");

  // bin zero always maps to zero range
  a_zero_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && (peak_bin == '0) |-> (range_q8_8 == '0))
    else $error("nonzero range for peak bin zero");

  // the range division separates the last bin from its result
  a_result_gap: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(sample_valid && sample_ready))
    else $error("result appeared straight after a bin");

  // a window change must recount before the next bin
  a_recount_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == REG_WINDOW_LENGTH) |=> !sample_ready)
    else $error("bin taken before window recount");

endmodule

bind sonar_range_extractor sre_chk u_sre_chk (
  .clk          (clk),
  .rst          (rst),
  .cfg_we       (cfg_we),
  .cfg_index    (cfg_index),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .range_q8_8   (range_q8_8),
  .peak_bin     (peak_bin),
  .peak_level   (peak_level)
);

`default_nettype wire
